// ----- hdl/ble_crc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLE CRC-24 checker package
// Transaction types, status codes and constants shared by the checker files.
// ----------------------------------------------------------------------------
package ble_crc_pkg;

  localparam int SKIP_BYTES = 4;
  localparam int MIN_LENGTH = SKIP_BYTES + 2 + 3;

  localparam logic [23:0] LFSR_POLY  = 24'hDA6000;
  localparam logic [23:0] SEED_RESET = 24'h555555;
  localparam logic [7:0]  COUNT_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    CRC_MATCH    = 2'd0,
    CRC_MISMATCH = 2'd1,
    CRC_SHORT    = 2'd2
  } check_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    check_status_t check_status;
    logic [23:0]   computed_crc;
    logic [23:0]   received_crc;
  } out_item_t;

endpackage

// ----- hdl/ble_crc_lfsr8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLE CRC-24 byte update
// Advances the reflected 24-bit LFSR over one byte, least significant bit first.
// ----------------------------------------------------------------------------
module ble_crc_lfsr8 (
  input  logic [23:0] lfsr_in,
  input  logic [7:0]  data_in,
  output logic [23:0] lfsr_out
);

  always_comb begin
    logic [23:0] r;
    logic [7:0]  v;
    logic        fb;
    r = lfsr_in;
    v = data_in;
    for (int k = 0; k < 8; k++) begin
      fb = v[0] ^ r[0];
      r  = r >> 1;
      v  = v >> 1;
      if (fb) begin
        r = r ^ ble_crc_pkg::LFSR_POLY;
      end
    end
    lfsr_out = r;
  end

endmodule

// ----- hdl/ble_crc_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLE CRC-24 packet state
// Holds the LFSR, byte count and tail delay line, and forms the check result.
// ----------------------------------------------------------------------------
module ble_crc_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  ble_crc_pkg::in_item_t  item,
  input  logic [23:0]            seed,
  output ble_crc_pkg::out_item_t result
);

  logic [23:0] lfsr_r, lfsr_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  tail_r   [3];
  logic [7:0]  tail_nxt [3];

  logic [23:0] lfsr_base;
  logic [23:0] lfsr_fed;
  logic [23:0] lfsr_after;
  logic [7:0]  count_inc;
  logic [23:0] rx_crc;

  assign lfsr_base = (count_r == 8'd0) ? seed : lfsr_r;

  ble_crc_lfsr8 u_lfsr8 (
    .lfsr_in  (lfsr_base),
    .data_in  (tail_r[0]),
    .lfsr_out (lfsr_fed)
  );

  assign lfsr_after = (count_r >= 8'(ble_crc_pkg::SKIP_BYTES + 3)) ? lfsr_fed : lfsr_base;
  assign count_inc  = (count_r == ble_crc_pkg::COUNT_MAX) ? count_r : count_r + 8'd1;
  assign rx_crc     = {item.data_byte, tail_r[2], tail_r[1]};

  always_comb begin
    if (count_inc < 8'(ble_crc_pkg::MIN_LENGTH)) begin
      result.check_status = ble_crc_pkg::CRC_SHORT;
      result.computed_crc = 24'd0;
      result.received_crc = 24'd0;
    end else begin
      result.check_status = (lfsr_after == rx_crc) ? ble_crc_pkg::CRC_MATCH
                                                   : ble_crc_pkg::CRC_MISMATCH;
      result.computed_crc = lfsr_after;
      result.received_crc = rx_crc;
    end
  end

  always_comb begin
    lfsr_nxt  = lfsr_r;
    count_nxt = count_r;
    tail_nxt  = tail_r;
    if (step_en) begin
      if (item.last_byte) begin
        lfsr_nxt    = seed;
        count_nxt   = 8'd0;
        tail_nxt[0] = 8'd0;
        tail_nxt[1] = 8'd0;
        tail_nxt[2] = 8'd0;
      end else begin
        lfsr_nxt    = lfsr_after;
        count_nxt   = count_inc;
        tail_nxt[0] = tail_r[1];
        tail_nxt[1] = tail_r[2];
        tail_nxt[2] = item.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r  <= ble_crc_pkg::SEED_RESET;
      count_r <= 8'd0;
      tail_r  <= '{default: 8'd0};
    end else begin
      lfsr_r  <= lfsr_nxt;
      count_r <= count_nxt;
      tail_r  <= tail_nxt;
    end
  end

  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.last_byte |=> count_r == 8'd0)
    else $error("Byte count not cleared after the final byte.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !item.last_byte && count_r != ble_crc_pkg::COUNT_MAX
      |=> count_r == $past(count_r) + 8'd1)
    else $error("Byte count did not advance by one.");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> count_r == $past(count_r))
    else $error("Byte count changed without a transaction.");

endmodule

// ----- hdl/ble_packet_crc24_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLE packet CRC-24 checker
// Checks the link-layer CRC of a packet received one byte per transaction.
// ----------------------------------------------------------------------------
// A final byte passes the input register and then the result register; it waits
// in the input register while an earlier result is still held by out_stall.
// Throughput: one byte per cycle while no final byte waits on a held result;
// the byte update is one unrolled LFSR step fed from the tail delay line.
// Reset clears the packet state and both valid flags and sets the seed to 0x555555.
// ----------------------------------------------------------------------------
module ble_packet_crc24_check (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  ble_crc_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output ble_crc_pkg::out_item_t out_item,
  input  logic                   cfg_wr_en,
  input  logic [23:0]            cfg_wr_data
);

  logic                   a_valid_r, a_valid_nxt;
  ble_crc_pkg::in_item_t  a_item_r;
  logic                   out_valid_r, out_valid_nxt;
  ble_crc_pkg::out_item_t out_item_r;
  logic [23:0]            seed_r;

  logic                   a_adv;
  logic                   in_take;
  logic                   out_take;
  ble_crc_pkg::out_item_t core_result;

  assign out_take = out_valid_r && !out_stall;
  assign a_adv    = a_valid_r && (!a_item_r.last_byte || !out_valid_r || !out_stall);
  assign in_stall = a_valid_r && !a_adv;
  assign in_take  = in_valid && !in_stall;

  ble_crc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (a_adv),
    .item    (a_item_r),
    .seed    (seed_r),
    .result  (core_result)
  );

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (a_adv && a_item_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= ble_crc_pkg::SEED_RESET;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_item_r <= in_item;
    end
    if (a_adv && a_item_r.last_byte) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> a_valid_r && a_item_r.last_byte && out_valid_r)
    else $error("Input stalled without a final byte waiting on the result register.");

  a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.check_status == ble_crc_pkg::CRC_SHORT
      |-> out_item_r.computed_crc == 24'd0 && out_item_r.received_crc == 24'd0)
    else $error("Short packet result carries non-zero CRC fields.");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("Pending result lost while the output was stalled.");

  a_nonlast_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !(a_adv && a_item_r.last_byte) |=> !out_valid_r)
    else $error("Result produced without a final byte.");

endmodule

// ----- sim/ble_packet_crc24_check_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BLE packet CRC-24 checker testbench
// Feeds packets byte by byte and checks every CRC report. A short table covers
// short packets, the minimum length and a bad CRC. Random packets then follow
// under several seeds, with one long packet that saturates the byte count.
// Both handshakes idle at random except in one steady phase, and each report
// is compared field by field with one predicted in the testbench.
// ----------------------------------------------------------------------------
module ble_packet_crc24_check_tb;
  import ble_crc_pkg::*;

  localparam int RESULT_LATENCY = 2;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 155;
  localparam int DIRECTED_ROWS  = 27;
  localparam int MAX_REPORTS    = 10;

  // Where a table byte comes from: the table itself or the running CRC.
  localparam logic [1:0] FROM_TABLE = 2'd0;
  localparam logic [1:0] CRC_LO     = 2'd1;
  localparam logic [1:0] CRC_MID    = 2'd2;
  localparam logic [1:0] CRC_HI     = 2'd3;

  // Shapes of random packets.
  localparam int WELL_FORMED = 0;
  localparam int CORRUPTED   = 1;
  localparam int RAW_BYTES   = 2;

  localparam out_item_t NO_REPORT    = '0;
  localparam out_item_t SHORT_REPORT = '{CRC_SHORT, 24'h000000, 24'h000000};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] fill;
    logic       known;
    out_item_t  report;
  } stim_row_t;

  stim_row_t stim_table [DIRECTED_ROWS] = '{
    '{8'hFF, 1'b1, FROM_TABLE, 1'b1, SHORT_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hFF, 1'b1, FROM_TABLE, 1'b1, SHORT_REPORT},
    '{8'hD6, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hBE, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h89, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h8E, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, CRC_LO,     1'b0, NO_REPORT},
    '{8'h00, 1'b0, CRC_MID,    1'b0, NO_REPORT},
    '{8'h00, 1'b1, CRC_HI,     1'b0, NO_REPORT},
    '{8'h8E, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h89, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hBE, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hD6, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'hFF, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b0, FROM_TABLE, 1'b0, NO_REPORT},
    '{8'h00, 1'b1, FROM_TABLE, 1'b0, NO_REPORT}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [23:0] cfg_wr_data = '0;

  // Predicted checker state.
  logic [23:0] seed_reg = SEED_RESET;
  logic [23:0] pkt_lfsr = SEED_RESET;
  logic [7:0]  pkt_count = '0;
  logic [7:0]  pkt_tail [3] = '{8'h00, 8'h00, 8'h00};

  out_item_t crc_report_q [$];
  int        mismatch_count = 0;
  int        items_sent = 0;
  int        idle_cycles = 0;
  bit        steady = 1'b0;

  ble_packet_crc24_check dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [23:0] crc24_shift_byte(input logic [23:0] crc,
                                                   input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb  = crc[0] ^ b[k];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ LFSR_POLY;
      end
    end
    return crc;
  endfunction

  function automatic bit next_crc_report(input in_item_t it, output out_item_t rep);
    logic [23:0] rx;
    rep = NO_REPORT;
    if (pkt_count == 0) begin
      pkt_lfsr = seed_reg;
    end
    if (pkt_count >= SKIP_BYTES + 3) begin
      pkt_lfsr = crc24_shift_byte(pkt_lfsr, pkt_tail[0]);
    end
    pkt_tail[0] = pkt_tail[1];
    pkt_tail[1] = pkt_tail[2];
    pkt_tail[2] = it.data_byte;
    if (pkt_count != COUNT_MAX) begin
      pkt_count = pkt_count + 8'd1;
    end
    if (!it.last_byte) begin
      return 1'b0;
    end
    if (pkt_count < MIN_LENGTH) begin
      rep = SHORT_REPORT;
    end else begin
      rx = {pkt_tail[2], pkt_tail[1], pkt_tail[0]};
      rep.check_status = (pkt_lfsr == rx) ? CRC_MATCH : CRC_MISMATCH;
      rep.computed_crc = pkt_lfsr;
      rep.received_crc = rx;
    end
    pkt_lfsr  = seed_reg;
    pkt_count = '0;
    pkt_tail  = '{8'h00, 8'h00, 8'h00};
    return 1'b1;
  endfunction

  function automatic int draw_gap();
    return steady ? 0 : int'($urandom_range(0, 16));
  endfunction

  task automatic send_byte(input in_item_t it, input logic known, input out_item_t known_rep);
    int        gap;
    out_item_t rep;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (next_crc_report(it, rep)) begin
      crc_report_q.push_back(known ? known_rep : rep);
    end
    items_sent++;
  endtask

  task automatic send_packet(input int len, input int shape);
    logic [7:0]  body [$];
    logic [23:0] crc;
    in_item_t    it;
    int          pos;
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
    end
    if (shape != RAW_BYTES && len >= MIN_LENGTH) begin
      crc = seed_reg;
      for (int i = SKIP_BYTES; i < len - 3; i++) begin
        crc = crc24_shift_byte(crc, body[i]);
      end
      body[len - 3] = crc[7:0];
      body[len - 2] = crc[15:8];
      body[len - 1] = crc[23:16];
      if (shape == CORRUPTED) begin
        pos       = $urandom_range(SKIP_BYTES, len - 1);
        body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    for (int i = 0; i < len; i++) begin
      it.data_byte = body[i];
      it.last_byte = (i == len - 1);
      send_byte(it, 1'b0, NO_REPORT);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (crc_report_q.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_seed(input logic [23:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    seed_reg  = value;
  endtask

  initial begin : stimulus
    in_item_t   it;
    logic [7:0] b;
    logic [23:0] frame_crc;
    int         frame_idx;
    int         phase_start;
    int         len;
    int         shape;
    int         pick;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    frame_crc = seed_reg;
    frame_idx = 0;
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (frame_idx == 0) begin
        frame_crc = seed_reg;
      end
      case (stim_table[r].fill)
        CRC_LO:  b = frame_crc[7:0];
        CRC_MID: b = frame_crc[15:8];
        CRC_HI:  b = frame_crc[23:16];
        default: begin
          b = stim_table[r].data;
          if (frame_idx >= SKIP_BYTES) begin
            frame_crc = crc24_shift_byte(frame_crc, b);
          end
        end
      endcase
      it.data_byte = b;
      it.last_byte = stim_table[r].last;
      send_byte(it, stim_table[r].known, stim_table[r].report);
      frame_idx = stim_table[r].last ? 0 : frame_idx + 1;
    end

    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1:       write_seed(24'h000000);
          2:       write_seed(24'hFFFFFF);
          4:       write_seed(SEED_RESET);
          default: write_seed(24'($urandom_range(0, 24'hFFFFFF)));
        endcase
      end
      steady      = (phase == 3);
      phase_start = items_sent;
      if (phase == 2) begin
        send_packet(270, WELL_FORMED);
      end
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick  = $urandom_range(0, 99);
        len   = (pick < 8) ? $urandom_range(1, MIN_LENGTH - 1) : $urandom_range(MIN_LENGTH, 20);
        pick  = $urandom_range(0, 9);
        shape = (pick == 0) ? CORRUPTED : (pick == 1) ? RAW_BYTES : WELL_FORMED;
        send_packet(len, shape);
        if ($urandom_range(0, 11) == 0) begin
          drain();
        end
      end
    end
    drain();

    if (mismatch_count == 0 && crc_report_q.size() == 0) begin
      $display("ble_packet_crc24_check_tb passed");
    end else begin
      $display("ble_packet_crc24_check_tb failed");
    end
    $finish;
  end

  initial begin : report_sink
    int        stall;
    out_item_t want;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_stall <= 1'b1;
        repeat (stall) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (crc_report_q.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("Unexpected transaction: status %0d computed %06h received %06h",
                   out_item.check_status, out_item.computed_crc, out_item.received_crc);
        end
        mismatch_count++;
      end else begin
        want = crc_report_q.pop_front();
        if (out_item.check_status !== want.check_status ||
            out_item.computed_crc !== want.computed_crc ||
            out_item.received_crc !== want.received_crc) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("Mismatch: expected status %0d computed %06h received %06h, got %0d %06h %06h",
                     want.check_status, want.computed_crc, want.received_crc,
                     out_item.check_status, out_item.computed_crc, out_item.received_crc);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when neither channel has moved a transaction for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("ble_packet_crc24_check_tb failed");
      $finish;
    end
  end

endmodule

// ----- files.f -----
hdl/ble_crc_pkg.sv
hdl/ble_crc_lfsr8.sv
hdl/ble_crc_core.sv
hdl/ble_packet_crc24_check.sv
sim/ble_packet_crc24_check_tb.sv
